// ----- rtl/ctpc_pkg.sv -----
// Shared constants and controller state type for the cosine template pose classifier.
package ctpc_pkg;

    localparam int CTPC_NUM_CLASSES = 4;
    localparam int CTPC_NUM_FRAMES  = 20;
    localparam int CTPC_NUM_JOINTS  = 20;
    localparam int CTPC_COORD_W     = 16;
    localparam int CTPC_FRAC_SHIFT  = 15;

    localparam logic ACT_TEMPLATE = 1'b0;
    localparam logic ACT_QUERY    = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_QQ,
        S_QROOT,
        S_DOT,
        S_TROOT,
        S_CHK,
        S_DIV,
        S_SCORE,
        S_MEANGO,
        S_MEAN,
        S_DONE
    } ctpc_state_t;

endpackage

// ----- rtl/ctpc_ram.sv -----
// Generic simple dual-port RAM with registered read.
module ctpc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/ctpc_sqrt.sv -----
// Iterative integer square root, one result bit per cycle.
module ctpc_sqrt #(
    parameter int W = 38
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [W-1:0]     operand,
    output logic             done,
    output logic [W/2-1:0]   root
);

    logic [W-1:0] v_reg, v_next;
    logic [W-1:0] res_reg, res_next;
    logic [W-1:0] bit_reg, bit_next;
    logic         run_reg, run_next;
    logic         done_reg, done_next;
    logic [W-1:0] trial;

    assign trial = res_reg + bit_reg;

    always_comb
    begin
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            v_next   = operand;
            res_next = '0;
            bit_next = W'(1) << (W - 2);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (v_reg >= trial)
            begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg == W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[W/2-1:0];

endmodule

// ----- rtl/ctpc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module ctpc_div #(
    parameter int NW = 53,
    parameter int DW = 38
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);

    localparam int CNT_W = $clog2(NW + 1);

    logic [DW-1:0]    rem_reg, rem_next;
    logic [NW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             ge;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = num;
            den_next = den;
            cnt_next = CNT_W'(NW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
            quo_next = {quo_reg[NW-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- rtl/cosine_template_pose_classifier.sv -----
// Top level: cosine-similarity nearest-template pose classifier.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+---------------------------------------------
//  command   | in        | start & !busy      | action pose_class frame_index coord_index
//            |           |                    | coord_value last_coord
//  result    | out       | done (one cycle)   | winner_class winner_score
//
// Template and query beats are written straight into the RAMs; busy stays low for them.
// A query beat with last_coord runs a classification: busy rises the next cycle
// and stays high through the done cycle. The query norm is streamed from the query RAM
// and rooted in the shared square root. Each template frame is then streamed, rooted in
// the same root unit, checked, divided in the shared bit-serial divider (skipped on a
// zero norm) and scored. Each class mean is a reciprocal multiply and a compare.
// Reset clears control state only; both RAMs hold garbage until written.
// The receiver cannot stall: done is a one-cycle strobe.
module cosine_template_pose_classifier
    import ctpc_pkg::*;
#(
    parameter int NUM_CLASSES = CTPC_NUM_CLASSES,
    parameter int NUM_FRAMES  = CTPC_NUM_FRAMES,
    parameter int NUM_JOINTS  = CTPC_NUM_JOINTS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [1:0]  pose_class,
    input  logic [4:0]  frame_index,
    input  logic [5:0]  coord_index,
    input  logic signed [15:0] coord_value,
    input  logic        last_coord,
    output logic        done,
    output logic [1:0]  winner_class,
    output logic signed [15:0] winner_score
);

    localparam int COORDS = 3 * NUM_JOINTS;
    localparam int CW     = $clog2(COORDS);
    localparam int CNT_W  = $clog2(COORDS + 1);
    localparam int DEPTH  = NUM_CLASSES * NUM_FRAMES * COORDS;
    localparam int AW     = $clog2(DEPTH);
    localparam int SQ_W   = ((32 + CW) + 1) / 2 * 2;   // sum of squares, even for the root
    localparam int RT_W   = SQ_W / 2;
    localparam int DOT_W  = 32 + CW;
    localparam int NW     = DOT_W + CTPC_FRAC_SHIFT;
    localparam int CLS_W  = $clog2(NUM_CLASSES);
    localparam int FR_W   = $clog2(NUM_FRAMES + 1);
    localparam int SUM_W  = 16 + FR_W;
    // mean = (|sum| * REC_M) >> REC_K, exact for every |sum| below 2^SUM_W
    localparam int REC_K  = SUM_W + FR_W;
    localparam int REC_W  = REC_K + 1;
    localparam int MP_W   = SUM_W + REC_W;
    localparam longint REC_M = ((longint'(1) << REC_K) + longint'(NUM_FRAMES) - 1)
                               / longint'(NUM_FRAMES);

    ctpc_state_t state_reg, state_next;

    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    vld_reg, vld_next;
    logic [AW-1:0]           tpl_raddr_reg, tpl_raddr_next;
    logic [CLS_W-1:0]        cls_reg, cls_next;
    logic [FR_W-1:0]         frm_reg, frm_next;
    logic [SQ_W-1:0]         acc_sq_reg, acc_sq_next;
    logic signed [DOT_W-1:0] dot_reg, dot_next;
    logic [RT_W-1:0]         nq_reg, nq_next;
    logic [SQ_W-1:0]         den_reg, den_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SUM_W-1:0]        mean_mag_reg, mean_mag_next;
    logic [CLS_W-1:0]        best_cls_reg, best_cls_next;
    logic signed [15:0]      best_score_reg, best_score_next;

    // command decode
    logic          accept;
    logic          qry_we;
    logic          tpl_we;
    logic [AW-1:0] tpl_waddr;

    assign accept = start && !busy;
    assign qry_we = accept && (action == ACT_QUERY) && (int'(coord_index) < COORDS);
    assign tpl_we = accept && (action == ACT_TEMPLATE) && (int'(pose_class) < NUM_CLASSES)
                    && (int'(frame_index) < NUM_FRAMES) && (int'(coord_index) < COORDS);
    assign tpl_waddr = AW'(int'(pose_class) * NUM_FRAMES * COORDS
                           + int'(frame_index) * COORDS + int'(coord_index));

    // state memories
    logic signed [15:0] q_rdata;
    logic signed [15:0] t_rdata;

    ctpc_ram #(.WIDTH(CTPC_COORD_W), .DEPTH(COORDS)) u_qry_ram (
        .clk   (clk),
        .we    (qry_we),
        .waddr (CW'(coord_index)),
        .wdata (coord_value),
        .raddr (cnt_reg[CW-1:0]),
        .rdata (q_rdata)
    );

    ctpc_ram #(.WIDTH(CTPC_COORD_W), .DEPTH(DEPTH)) u_tpl_ram (
        .clk   (clk),
        .we    (tpl_we),
        .waddr (tpl_waddr),
        .wdata (coord_value),
        .raddr (tpl_raddr_reg),
        .rdata (t_rdata)
    );

    // shared arithmetic units
    logic            sq_start;
    logic            sq_done;
    logic [RT_W-1:0] sq_root;
    logic            div_start;
    logic [NW-1:0]   div_num;
    logic [SQ_W-1:0] div_den;
    logic            div_done;
    logic [NW-1:0]   div_quo;

    ctpc_sqrt #(.W(SQ_W)) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sq_start),
        .operand (acc_sq_reg),
        .done    (sq_done),
        .root    (sq_root)
    );

    ctpc_div #(.NW(NW), .DW(SQ_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // streaming: address issued while cnt < COORDS, data lands in the next cycle
    logic               issue;
    logic               stream_end;
    logic               last_frame;
    logic               last_class;
    logic signed [31:0] qq_prod;
    logic signed [31:0] qt_prod;
    logic signed [31:0] tt_prod;
    logic [DOT_W-1:0]   dot_mag;
    logic [SUM_W-1:0]   sum_mag;
    logic [MP_W-1:0]    mean_prod;
    logic signed [15:0] frame_score;
    logic signed [15:0] mean_score;

    assign issue      = (cnt_reg != CNT_W'(COORDS));
    assign stream_end = !issue && !vld_reg;
    assign last_frame = (frm_reg == FR_W'(NUM_FRAMES - 1));
    assign last_class = (cls_reg == CLS_W'(NUM_CLASSES - 1));
    assign qq_prod    = q_rdata * q_rdata;
    assign qt_prod    = q_rdata * t_rdata;
    assign tt_prod    = t_rdata * t_rdata;
    assign dot_mag    = dot_reg[DOT_W-1] ? DOT_W'(-dot_reg) : DOT_W'(dot_reg);
    assign sum_mag    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign mean_prod  = MP_W'(sum_mag) * MP_W'(REC_M);

    // quotient magnitude -> saturated Q1.15; zero denominator scores 0
    always_comb
    begin
        priority if (den_reg == '0)
        begin
            frame_score = '0;
        end
        else if (dot_reg[DOT_W-1])
        begin
            frame_score = (div_quo >= NW'(32768)) ? 16'sh8000 : 16'(~div_quo[15:0] + 16'd1);
        end
        else
        begin
            frame_score = (div_quo > NW'(32767)) ? 16'sh7fff : div_quo[15:0];
        end
    end

    // truncated toward zero: sign of the sum put back on the quotient magnitude
    assign mean_score = sum_reg[SUM_W-1] ? 16'(~mean_mag_reg[15:0] + 16'd1)
                                         : mean_mag_reg[15:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (action == ACT_QUERY) && last_coord)
                begin
                    state_next = S_QQ;
                end
            end
            S_QQ:     if (stream_end) state_next = S_QROOT;
            S_QROOT:  if (sq_done) state_next = S_DOT;
            S_DOT:    if (stream_end) state_next = S_TROOT;
            S_TROOT:  if (sq_done) state_next = S_CHK;
            S_CHK:    state_next = (den_reg == '0) ? S_SCORE : S_DIV;
            S_DIV:    if (div_done) state_next = S_SCORE;
            S_SCORE:  state_next = last_frame ? S_MEANGO : S_DOT;
            S_MEANGO: state_next = S_MEAN;
            S_MEAN:   state_next = last_class ? S_DONE : S_DOT;
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // unit control outputs
    always_comb
    begin
        sq_start  = 1'b0;
        div_start = 1'b0;
        div_num   = {dot_mag, CTPC_FRAC_SHIFT'(0)};
        div_den   = den_reg;
        unique case (state_reg)
            S_QQ, S_DOT: sq_start = stream_end;
            S_CHK:       div_start = (den_reg != '0);
            default:
            begin
                sq_start  = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        cnt_next        = cnt_reg;
        vld_next        = 1'b0;
        tpl_raddr_next  = tpl_raddr_reg;
        cls_next        = cls_reg;
        frm_next        = frm_reg;
        acc_sq_next     = acc_sq_reg;
        dot_next        = dot_reg;
        nq_next         = nq_reg;
        den_next        = den_reg;
        sum_next        = sum_reg;
        mean_mag_next   = mean_mag_reg;
        best_cls_next   = best_cls_reg;
        best_score_next = best_score_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next       = '0;
                acc_sq_next    = '0;
                tpl_raddr_next = '0;
                cls_next       = '0;
                frm_next       = '0;
                sum_next       = '0;
            end
            S_QQ:
            begin
                vld_next = issue;
                if (issue)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (vld_reg)
                begin
                    acc_sq_next = acc_sq_reg + SQ_W'($unsigned(qq_prod));
                end
            end
            S_QROOT:
            begin
                cnt_next    = '0;
                acc_sq_next = '0;
                dot_next    = '0;
                if (sq_done)
                begin
                    nq_next = sq_root;
                end
            end
            S_DOT:
            begin
                vld_next = issue;
                if (issue)
                begin
                    cnt_next       = cnt_reg + CNT_W'(1);
                    tpl_raddr_next = tpl_raddr_reg + AW'(1);
                end
                if (vld_reg)
                begin
                    acc_sq_next = acc_sq_reg + SQ_W'($unsigned(tt_prod));
                    dot_next    = dot_reg + DOT_W'(qt_prod);
                end
            end
            S_TROOT:
            begin
                if (sq_done)
                begin
                    den_next = SQ_W'(nq_reg) * SQ_W'(sq_root);
                end
            end
            S_SCORE:
            begin
                sum_next    = sum_reg + SUM_W'(frame_score);
                frm_next    = frm_reg + FR_W'(1);
                cnt_next    = '0;
                acc_sq_next = '0;
                dot_next    = '0;
            end
            S_MEANGO:
            begin
                mean_mag_next = SUM_W'(mean_prod >> REC_K);
            end
            S_MEAN:
            begin
                if ((cls_reg == '0) || (mean_score > best_score_reg))
                begin
                    best_cls_next   = cls_reg;
                    best_score_next = mean_score;
                end
                cls_next = cls_reg + CLS_W'(1);
                frm_next = '0;
                sum_next = '0;
            end
            default:
            begin
                vld_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            vld_reg       <= 1'b0;
            tpl_raddr_reg <= '0;
            cls_reg       <= '0;
            frm_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            vld_reg       <= vld_next;
            tpl_raddr_reg <= tpl_raddr_next;
            cls_reg       <= cls_next;
            frm_reg       <= frm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_sq_reg     <= acc_sq_next;
        dot_reg        <= dot_next;
        nq_reg         <= nq_next;
        den_reg        <= den_next;
        sum_reg        <= sum_next;
        mean_mag_reg   <= mean_mag_next;
        best_cls_reg   <= best_cls_next;
        best_score_reg <= best_score_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = (state_reg == S_DONE);
    assign winner_class = 2'(best_cls_reg);
    assign winner_score = best_score_reg;

    // checks
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe longer than one cycle");

    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy held after result beat");

    a_classify_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action && last_coord) |=> (busy && !done))
        else $error("last query beat did not start classification");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(COORDS))
        else $error("stream counter past coordinate count");

endmodule

// ----- bench/tb_cosine_template_pose_classifier.sv -----
// Testbench for the cosine template pose classifier: table-driven and random beats.
module tb_cosine_template_pose_classifier
    import ctpc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORDS     = 3 * CTPC_NUM_JOINTS;
    localparam int IDLE_LIMIT = 60000;   // watchdog limit; one classification must fit within it
    localparam int N_RANDOM   = 1500;

    // one command beat plus an optional hand-typed expectation
    typedef struct {
        logic        act;
        logic [1:0]  cls;
        logic [4:0]  frm;
        logic [5:0]  crd;
        logic [15:0] val;
        logic        lst;
        logic        typed;
        logic [1:0]  e_cls;
        logic [15:0] e_score;
    } beat_t;

    typedef struct {
        logic [1:0]  cls;
        logic [15:0] score;
    } pose_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        action;
    logic [1:0]  pose_class;
    logic [4:0]  frame_index;
    logic [5:0]  coord_index;
    logic signed [15:0] coord_value;
    logic        last_coord;
    logic        done;
    logic [1:0]  winner_class;
    logic signed [15:0] winner_score;

    cosine_template_pose_classifier i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .pose_class   (pose_class),
        .frame_index  (frame_index),
        .coord_index  (coord_index),
        .coord_value  (coord_value),
        .last_coord   (last_coord),
        .done         (done),
        .winner_class (winner_class),
        .winner_score (winner_score)
    );

    // shadow copies of the template RAM and the query vector
    int    tmpl_mem [CTPC_NUM_CLASSES][CTPC_NUM_FRAMES][COORDS];
    int    qry_mem  [COORDS];
    pose_t pending_poses[$];

    int mismatches  = 0;
    int n_results   = 0;
    int n_beats     = 0;
    int idle_pct    = 0;    // chance per beat that the sender holds off
    int idle_cycles = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // floor(sqrt(v)), digit-by-digit
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // best class by mean cosine score over the frames; strict > keeps lowest index on ties
    function automatic pose_t best_pose();
        pose_t           p;
        longint unsigned qq;
        longint unsigned nq;
        longint unsigned tt;
        longint unsigned den;
        longint          dot;
        longint          s;
        longint          sum;
        longint          mean;
        longint          best_mean;
        int              best;
        qq = 0;
        for (int k = 0; k < COORDS; k++)
            qq += longint'(qry_mem[k]) * longint'(qry_mem[k]);
        nq        = floor_sqrt(qq);
        best      = 0;
        best_mean = 0;
        for (int c = 0; c < CTPC_NUM_CLASSES; c++)
        begin
            sum = 0;
            for (int f = 0; f < CTPC_NUM_FRAMES; f++)
            begin
                dot = 0;
                tt  = 0;
                for (int k = 0; k < COORDS; k++)
                begin
                    dot += longint'(qry_mem[k]) * longint'(tmpl_mem[c][f][k]);
                    tt  += longint'(tmpl_mem[c][f][k]) * longint'(tmpl_mem[c][f][k]);
                end
                den = nq * floor_sqrt(tt);
                if (den == 0)
                    s = 0;              // zero norm scores nothing
                else
                begin
                    s = (dot * 32768) / longint'(den);
                    if (s > 32767)
                        s = 32767;
                    if (s < -32768)
                        s = -32768;
                end
                sum += s;
            end
            mean = sum / CTPC_NUM_FRAMES;
            if (c == 0 || mean > best_mean)
            begin
                best      = c;
                best_mean = mean;
            end
        end
        p.cls   = best[1:0];
        p.score = best_mean[15:0];
        return p;
    endfunction

    // apply an accepted beat to the shadow state; queue a pose when it classifies
    task automatic track_beat(input beat_t b);
        pose_t p;
        if (b.act == ACT_TEMPLATE)
        begin
            if (b.cls < CTPC_NUM_CLASSES && b.frm < CTPC_NUM_FRAMES && b.crd < COORDS)
                tmpl_mem[b.cls][b.frm][b.crd] = int'($signed(b.val));
        end
        else
        begin
            if (b.crd < COORDS)
                qry_mem[b.crd] = int'($signed(b.val));
            if (b.lst)
            begin
                p = best_pose();
                if (b.typed)
                begin
                    p.cls   = b.e_cls;
                    p.score = b.e_score;
                end
                pending_poses.push_back(p);
            end
        end
    endtask

    // drive one beat at the falling edge, hold until start & !busy at a rising edge
    task automatic send_beat(input beat_t b);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        action      = b.act;
        pose_class  = b.cls;
        frame_index = b.frm;
        coord_index = b.crd;
        coord_value = b.val;
        last_coord  = b.lst;
        start       = 1'b1;
        do
            @(posedge clk);
        while (busy);
        n_beats++;
        track_beat(b);
    endtask

    function automatic beat_t mk(input logic a, input int c, input int f, input int k,
                                 input int v, input logic l);
        beat_t b;
        b.act     = a;
        b.cls     = c[1:0];
        b.frm     = f[4:0];
        b.crd     = k[5:0];
        b.val     = v[15:0];
        b.lst     = l;
        b.typed   = 1'b0;
        b.e_cls   = '0;
        b.e_score = '0;
        return b;
    endfunction

    function automatic logic [15:0] rand_value();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(8192)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    // result checker: done is a one-cycle strobe, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            n_results++;
            if (pending_poses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing pending: class %0d score %0d",
                             winner_class, winner_score);
            end
            else
            begin
                if (winner_class !== pending_poses[0].cls ||
                    winner_score !== pending_poses[0].score)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: expected class %0d score %0d, got class %0d score %0d",
                                 pending_poses[0].cls, $signed(pending_poses[0].score),
                                 winner_class, winner_score);
                end
                void'(pending_poses.pop_front());
            end
        end
    end

    // watchdog: cycles without any accepted beat or result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("ERROR: watchdog expired, %0d poses pending", pending_poses.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    beat_t table_beats[$];
    beat_t b;
    int    roll;

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        action      = ACT_TEMPLATE;
        pose_class  = '0;
        frame_index = '0;
        coord_index = '0;
        coord_value = '0;
        last_coord  = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // both RAMs are garbage after reset: zero every entry first
        for (int c = 0; c < CTPC_NUM_CLASSES; c++)
            for (int f = 0; f < CTPC_NUM_FRAMES; f++)
                for (int k = 0; k < COORDS; k++)
                    send_beat(mk(ACT_TEMPLATE, c, f, k, 0, 1'b0));
        for (int k = 0; k < COORDS; k++)
            send_beat(mk(ACT_QUERY, 0, 0, k, 0, 1'b0));

        // directed table; typed rows are the ones obvious from the zeroed state
        table_beats.push_back(mk(ACT_QUERY,    0,  0,  0,  32767, 1'b0));
        b = mk(ACT_QUERY, 0, 0, 59, -32768, 1'b1);      // all templates zero: tie at 0
        b.typed = 1'b1;
        table_beats.push_back(b);
        table_beats.push_back(mk(ACT_TEMPLATE, 3, 19, 59, -32768, 1'b1)); // last ignored
        table_beats.push_back(mk(ACT_TEMPLATE, 3, 19,  0,  32767, 1'b0));
        table_beats.push_back(mk(ACT_TEMPLATE, 1,  0, 59, -32768, 1'b0));
        table_beats.push_back(mk(ACT_TEMPLATE, 2, 31,  0,      1, 1'b0)); // frame out of range
        table_beats.push_back(mk(ACT_TEMPLATE, 2,  0, 63,      1, 1'b0)); // coord out of range
        table_beats.push_back(mk(ACT_QUERY,    0,  0, 63,      5, 1'b1)); // dropped, still runs
        table_beats.push_back(mk(ACT_QUERY,    3, 31, 30,     -1, 1'b1));
        table_beats.push_back(mk(ACT_QUERY,    0,  0,  0,      0, 1'b0));
        table_beats.push_back(mk(ACT_QUERY,    0,  0, 30,      0, 1'b0));
        b = mk(ACT_QUERY, 0, 0, 59, 0, 1'b1);            // zero query norm
        b.typed = 1'b1;
        table_beats.push_back(b);
        table_beats.push_back(mk(ACT_TEMPLATE, 0,  0, 10,  16384, 1'b0));
        table_beats.push_back(mk(ACT_QUERY,    0,  0, 10,  16384, 1'b1));
        foreach (table_beats[i])
            send_beat(table_beats[i]);

        // random beats in three idling phases
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 3)
            begin
                // hold off until every pose has come back
                wait (pending_poses.size() == 0);
                idle_pct = 49;
            end
            else if (i == 0)
                idle_pct = 11;
            else if (i == 2 * N_RANDOM / 3)
                idle_pct = 0;
            roll = $urandom_range(99);
            if (roll < 68)
                b = mk(ACT_TEMPLATE, $urandom_range(3), $urandom_range(19),
                       $urandom_range(COORDS - 1), 0, 1'b0);
            else if (roll < 90)
                b = mk(ACT_QUERY, $urandom_range(3), $urandom_range(31),
                       $urandom_range(COORDS - 1), 0, 1'b0);
            else if (roll < 95)
                b = mk(ACT_QUERY, $urandom_range(3), $urandom_range(31),
                       $urandom_range(COORDS - 1), 0, 1'b1);
            else
                // noise: any index pattern, out-of-range writes, stray last marks
                b = mk($urandom_range(1), $urandom_range(3), $urandom_range(31),
                       $urandom_range(63), 0, $urandom_range(1));
            if (b.act == ACT_TEMPLATE && roll >= 95 &&
                b.frm < CTPC_NUM_FRAMES && b.crd < COORDS)
                b.frm = 5'd20 + 5'($urandom_range(11));   // keep noise out of the store
            b.val = rand_value();
            send_beat(b);
        end
        @(negedge clk);
        start = 1'b0;

        wait (pending_poses.size() == 0);
        repeat (200) @(posedge clk);

        $display("Covered %0d beats (template fill, directed table, random) and %0d poses.",
                 n_beats, n_results);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
